/* rtl/tcc_pkg.sv */
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and constants for the text console cursor engine.
// ----------------------------------------------------------------------------
package tcc_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int FUNC_W = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CELL_W = 16;

  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  localparam logic [CELL_W-1:0] CELL_BLANK = 16'h0720;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_WAIT,
    S_SCR_RD,
    S_SCR_WR,
    S_SCR_FILL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [CELL_W-1:0] cell_value;
    logic              scrolled;
  } res_t;

endpackage

/* rtl/tcc_if.sv */
// ----------------------------------------------------------------------------
// tcc_cmd_if / tcc_res_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface tcc_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [tcc_pkg::FUNC_W-1:0]  func;
  logic [tcc_pkg::CHAR_W-1:0]  char_code;
  logic [tcc_pkg::ATTR_W-1:0]  attribute;
  logic [tcc_pkg::ROW_W-1:0]   read_row;
  logic [tcc_pkg::COL_W-1:0]   read_col;

  modport source (output valid, func, char_code, attribute, read_row, read_col,
                  input ready);
  modport sink   (input valid, func, char_code, attribute, read_row, read_col,
                  output ready);
endinterface

interface tcc_res_if;
  logic                        valid;
  logic                        ready;
  logic [tcc_pkg::ROW_W-1:0]   cursor_row;
  logic [tcc_pkg::COL_W-1:0]   cursor_col;
  logic [tcc_pkg::CELL_W-1:0]  cell_value;
  logic                        scrolled;

  modport source (output valid, cursor_row, cursor_col, cell_value, scrolled,
                  input ready);
  modport sink   (input valid, cursor_row, cursor_col, cell_value, scrolled,
                  output ready);
endinterface

/* rtl/tcc_screen_ram.sv */
// ----------------------------------------------------------------------------
// tcc_screen_ram
// Screen cell store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tcc_screen_ram #(
  parameter int DEPTH = tcc_pkg::ROWS_DEF * tcc_pkg::COLUMNS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [tcc_pkg::CELL_W-1:0] wdata,
  input  logic [AW-1:0]              raddr,
  output logic [tcc_pkg::CELL_W-1:0] rdata
);

  logic [tcc_pkg::CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/tcc_seq.sv */
// ----------------------------------------------------------------------------
// tcc_seq
// Sequencer: cursor state, command decode and the shared address counter
// that drives clear, scroll-copy and blank-fill sweeps over the screen store.
// ----------------------------------------------------------------------------
module tcc_seq #(
  parameter int COLUMNS = tcc_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcc_pkg::ROWS_DEF,
  parameter int AW      = $clog2(ROWS * COLUMNS)
) (
  input  logic                       clk,
  input  logic                       rst,
  tcc_cmd_if.sink                    cmd,
  output logic                       res_valid,
  output tcc_pkg::res_t              res,
  input  logic                       res_free,
  output logic                       we,
  output logic [AW-1:0]              waddr,
  output logic [tcc_pkg::CELL_W-1:0] wdata,
  output logic [AW-1:0]              raddr,
  input  logic [tcc_pkg::CELL_W-1:0] rdata
);

  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW = $clog2(COLUMNS);

  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(ROWS * COLUMNS - 1);
  localparam logic [AW-1:0] COPY_END = AW'((ROWS - 1) * COLUMNS - 1);
  localparam logic [AW-1:0] ROW_STEP = AW'(COLUMNS);

  tcc_pkg::state_t state, state_next;

  logic [RW-1:0]                 row, row_next;
  logic [CW-1:0]                 col, col_next;
  logic [AW-1:0]                 ptr, ptr_next;
  logic [tcc_pkg::ATTR_W-1:0]    attr, attr_next;
  logic [tcc_pkg::CELL_W-1:0]    rd_cell, rd_cell_next;
  logic                          scrolled, scrolled_next;
  logic                          clr_reply, clr_reply_next;

  logic [AW-1:0] cur_addr;
  logic [AW-1:0] rd_addr;
  logic          rd_in_range;

  assign cur_addr    = AW'(row) * ROW_STEP + AW'(col);
  assign rd_addr     = AW'(cmd.read_row) * ROW_STEP + AW'(cmd.read_col);
  assign rd_in_range = (32'(cmd.read_row) < 32'(ROWS)) && (32'(cmd.read_col) < 32'(COLUMNS));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tcc_pkg::S_CLEAR;
      row       <= '0;
      col       <= '0;
      ptr       <= '0;
      clr_reply <= 1'b0;
      scrolled  <= 1'b0;
    end else begin
      state     <= state_next;
      row       <= row_next;
      col       <= col_next;
      ptr       <= ptr_next;
      clr_reply <= clr_reply_next;
      scrolled  <= scrolled_next;
    end
  end

  always_ff @(posedge clk) begin
    attr    <= attr_next;
    rd_cell <= rd_cell_next;
  end

  always_comb begin
    state_next     = state;
    row_next       = row;
    col_next       = col;
    ptr_next       = ptr;
    attr_next      = attr;
    rd_cell_next   = rd_cell;
    scrolled_next  = scrolled;
    clr_reply_next = clr_reply;
    we             = 1'b0;
    waddr          = cur_addr;
    wdata          = {cmd.attribute, cmd.char_code};
    raddr          = ptr + ROW_STEP;
    cmd.ready      = 1'b0;
    res_valid      = 1'b0;

    case (state)
      tcc_pkg::S_CLEAR: begin
        we    = 1'b1;
        waddr = ptr;
        wdata = tcc_pkg::CELL_BLANK;
        if (ptr == PTR_LAST) begin
          ptr_next       = '0;
          clr_reply_next = 1'b0;
          state_next     = clr_reply ? tcc_pkg::S_DONE : tcc_pkg::S_IDLE;
        end else begin
          ptr_next = ptr + AW'(1);
        end
      end

      tcc_pkg::S_IDLE: begin
        cmd.ready = 1'b1;
        raddr     = rd_addr;
        if (cmd.valid) begin
          rd_cell_next  = '0;
          scrolled_next = 1'b0;
          attr_next     = cmd.attribute;
          state_next    = tcc_pkg::S_DONE;
          case (cmd.func)
            tcc_pkg::FUNC_PUT: begin
              if (cmd.char_code == tcc_pkg::CH_NEWLINE) begin
                col_next = '0;
                if (row == ROW_LAST) begin
                  ptr_next      = '0;
                  scrolled_next = 1'b1;
                  state_next    = tcc_pkg::S_SCR_RD;
                end else begin
                  row_next = row + RW'(1);
                end
              end else if (cmd.char_code == tcc_pkg::CH_BACKSPACE) begin
                if (col != '0) begin
                  col_next = col - CW'(1);
                  we       = 1'b1;
                  waddr    = cur_addr - AW'(1);
                  wdata    = {cmd.attribute, tcc_pkg::CH_SPACE};
                end
              end else begin
                we = 1'b1;
                if (col == COL_LAST) begin
                  col_next = '0;
                  if (row == ROW_LAST) begin
                    ptr_next      = '0;
                    scrolled_next = 1'b1;
                    state_next    = tcc_pkg::S_SCR_RD;
                  end else begin
                    row_next = row + RW'(1);
                  end
                end else begin
                  col_next = col + CW'(1);
                end
              end
            end
            tcc_pkg::FUNC_CLEAR: begin
              row_next       = '0;
              col_next       = '0;
              ptr_next       = '0;
              clr_reply_next = 1'b1;
              state_next     = tcc_pkg::S_CLEAR;
            end
            tcc_pkg::FUNC_READ: begin
              if (rd_in_range) begin
                state_next = tcc_pkg::S_RD_WAIT;
              end
            end
            default: begin
              state_next = tcc_pkg::S_DONE;
            end
          endcase
        end
      end

      tcc_pkg::S_RD_WAIT: begin
        rd_cell_next = rdata;
        state_next   = tcc_pkg::S_DONE;
      end

      // copy: fetch the cell one row below, then write it back one row up
      tcc_pkg::S_SCR_RD: begin
        state_next = tcc_pkg::S_SCR_WR;
      end

      tcc_pkg::S_SCR_WR: begin
        we       = 1'b1;
        waddr    = ptr;
        wdata    = rdata;
        ptr_next = ptr + AW'(1);
        state_next = (ptr == COPY_END) ? tcc_pkg::S_SCR_FILL : tcc_pkg::S_SCR_RD;
      end

      tcc_pkg::S_SCR_FILL: begin
        we    = 1'b1;
        waddr = ptr;
        wdata = {attr, tcc_pkg::CH_SPACE};
        if (ptr == PTR_LAST) begin
          ptr_next   = '0;
          state_next = tcc_pkg::S_DONE;
        end else begin
          ptr_next = ptr + AW'(1);
        end
      end

      tcc_pkg::S_DONE: begin
        res_valid = 1'b1;
        if (res_free) begin
          state_next = tcc_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = tcc_pkg::S_IDLE;
      end
    endcase
  end

  assign res.cursor_row = tcc_pkg::ROW_W'(row);
  assign res.cursor_col = tcc_pkg::COL_W'(col);
  assign res.cell_value = rd_cell;
  assign res.scrolled   = scrolled;

`ifndef NO_ASSERTIONS
  a_col_range: assert property (@(posedge clk) disable iff (rst) col <= COL_LAST)
    else $error("cursor column beyond last column");

  a_row_range: assert property (@(posedge clk) disable iff (rst) row <= ROW_LAST)
    else $error("cursor row beyond last row");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
      (state == tcc_pkg::S_DONE && scrolled) |-> (row == ROW_LAST && col == '0))
    else $error("scroll did not leave cursor at start of bottom row");

  a_clear_start: assert property (@(posedge clk) disable iff (rst)
      (cmd.valid && cmd.ready && cmd.func == tcc_pkg::FUNC_CLEAR)
      |=> (state == tcc_pkg::S_CLEAR && ptr == '0 && row == '0 && col == '0))
    else $error("clear beat did not start sweep from home");

  a_no_write_when_done: assert property (@(posedge clk) disable iff (rst)
      (state == tcc_pkg::S_DONE || state == tcc_pkg::S_RD_WAIT) |-> !we)
    else $error("store written while no sweep or put is in progress");
`endif

endmodule

/* rtl/text_console_cursor_engine.sv */
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// Text screen of ROWS x COLUMNS cells with a cursor; put, clear, read beats.
// ----------------------------------------------------------------------------
// Put char / read / unused code: reported through S_DONE to the result register.
// Scroll: every row but the top one is copied one row up, then the bottom row is
//   blank-filled, paced by the single store port pair doing one read and one write per copied cell.
// Clear: a blank-fill sweep of every cell. One command beat in flight at a time.
// Reset: synchronous; a blank-fill sweep of every cell runs first, cmd.ready
//   stays low until it is done.
module text_console_cursor_engine #(
  parameter int COLUMNS = tcc_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcc_pkg::ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  tcc_cmd_if.sink    cmd,
  tcc_res_if.source  res
);

  localparam int DEPTH = ROWS * COLUMNS;
  localparam int AW    = $clog2(DEPTH);

  logic                       we;
  logic [AW-1:0]              waddr;
  logic [tcc_pkg::CELL_W-1:0] wdata;
  logic [AW-1:0]              raddr;
  logic [tcc_pkg::CELL_W-1:0] rdata;

  logic          seq_valid;
  tcc_pkg::res_t seq_res;
  logic          res_free;

  logic          out_valid;
  tcc_pkg::res_t out_res;

  tcc_screen_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  tcc_seq #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .AW      (AW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .res_valid (seq_valid),
    .res       (seq_res),
    .res_free  (res_free),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .raddr     (raddr),
    .rdata     (rdata)
  );

  // output register: free when empty or its beat is taken this cycle
  assign res_free = !out_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_free) begin
      out_valid <= seq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_free && seq_valid) begin
      out_res <= seq_res;
    end
  end

  assign res.valid      = out_valid;
  assign res.cursor_row = out_res.cursor_row;
  assign res.cursor_col = out_res.cursor_col;
  assign res.cell_value = out_res.cell_value;
  assign res.scrolled   = out_res.scrolled;

endmodule

/* bench/text_console_cursor_engine_test.sv */
// ----------------------------------------------------------------------------
// text_console_cursor_engine_test
// Self-checking bench for the text console. A scoreboard keeps a mirror of
// the screen and cursor, predicts the report of every accepted command beat
// and compares it field by field with the result beats. A short directed run
// is followed by random text, control characters, reads, clears and unused
// codes, under four idling patterns and a long receiver hold-off.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tcc_pkg::*;

  localparam int SCREEN_COLS   = COLUMNS_DEF;
  localparam int SCREEN_ROWS   = ROWS_DEF;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  // a scroll copies every row but the top one through the store, so they are rationed
  localparam int SCROLL_BUDGET = 80;
  localparam int PHASE_ITEMS   = 385;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT   = 2_000_000;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [CHAR_W-1:0] char_code;
    logic [ATTR_W-1:0] attribute;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
  } console_cmd_t;

  class console_scoreboard;
    logic [CELL_W-1:0] cells [SCREEN_ROWS*SCREEN_COLS];
    int   row_now;
    int   col_now;
    res_t due_reports [$];
    int   commands, chars, scrolls, clears, reads, stray_reads, mismatches;

    function new();
      wipe_screen();
    endfunction

    function void wipe_screen();
      foreach (cells[i]) cells[i] = CELL_BLANK;
      row_now = 0;
      col_now = 0;
    endfunction

    function int pending();
      return due_reports.size();
    endfunction

    // one row down; past the bottom the screen moves up and gets a blank row
    function bit line_feed(logic [ATTR_W-1:0] attr);
      row_now++;
      if (row_now < SCREEN_ROWS) return 1'b0;
      for (int i = 0; i < (SCREEN_ROWS-1)*SCREEN_COLS; i++)
        cells[i] = cells[i+SCREEN_COLS];
      for (int x = 0; x < SCREEN_COLS; x++)
        cells[(SCREEN_ROWS-1)*SCREEN_COLS + x] = {attr, CH_SPACE};
      row_now = SCREEN_ROWS - 1;
      scrolls++;
      return 1'b1;
    endfunction

    function void note_command(console_cmd_t c);
      res_t r;
      r = '0;
      commands++;
      case (c.func)
        FUNC_PUT: begin
          if (c.char_code == CH_NEWLINE) begin
            col_now = 0;
            r.scrolled = line_feed(c.attribute);
          end else if (c.char_code == CH_BACKSPACE) begin
            if (col_now > 0) begin
              col_now--;
              cells[row_now*SCREEN_COLS + col_now] = {c.attribute, CH_SPACE};
            end
          end else begin
            chars++;
            cells[row_now*SCREEN_COLS + col_now] = {c.attribute, c.char_code};
            col_now++;
            if (col_now >= SCREEN_COLS) begin
              col_now = 0;
              r.scrolled = line_feed(c.attribute);
            end
          end
        end
        FUNC_CLEAR: begin
          clears++;
          wipe_screen();
        end
        FUNC_READ: begin
          reads++;
          if (int'(c.read_row) < SCREEN_ROWS && int'(c.read_col) < SCREEN_COLS)
            r.cell_value = cells[int'(c.read_row)*SCREEN_COLS + int'(c.read_col)];
          else
            stray_reads++;
        end
        default: ;
      endcase
      r.cursor_row = ROW_W'(row_now);
      r.cursor_col = COL_W'(col_now);
      due_reports.push_back(r);
    endfunction

    function void check_report(res_t got);
      res_t want;
      if (due_reports.size() == 0) begin
        $error("result beat with nothing expected: row %0d col %0d cell %h",
               got.cursor_row, got.cursor_col, got.cell_value);
        mismatches++;
        return;
      end
      want = due_reports.pop_front();
      if (got.cursor_row !== want.cursor_row) begin
        $error("cursor_row: expected %0d, got %0d", want.cursor_row, got.cursor_row);
        mismatches++;
      end
      if (got.cursor_col !== want.cursor_col) begin
        $error("cursor_col: expected %0d, got %0d", want.cursor_col, got.cursor_col);
        mismatches++;
      end
      if (got.cell_value !== want.cell_value) begin
        $error("cell_value: expected %h, got %h", want.cell_value, got.cell_value);
        mismatches++;
      end
      if (got.scrolled !== want.scrolled) begin
        $error("scrolled: expected %0d, got %0d", want.scrolled, got.scrolled);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  bit   hold_rx_req    = 1'b0;
  int   cycle_count    = 0;
  int   send_plan [4]  = '{0, 58, 0, 27};
  int   recv_plan [4]  = '{0, 0, 58, 27};

  console_scoreboard board = new();

  tcc_cmd_if cmd_ch ();
  tcc_res_if res_ch ();

  text_console_cursor_engine uut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (res_ch.valid && res_ch.ready)
        board.check_report({res_ch.cursor_row, res_ch.cursor_col,
                            res_ch.cell_value, res_ch.scrolled});
    end
  end

  // result side: random stalls, or one long hold-off on request
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rx_req) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx_req = 1'b0;
      end
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("run stopped at the cycle limit, %0d reports outstanding", board.pending());
    $display("CHECK FAILED");
    $finish;
  end

  function automatic console_cmd_t make_cmd(logic [FUNC_W-1:0] func,
                                            logic [CHAR_W-1:0] ch,
                                            logic [ATTR_W-1:0] attr,
                                            logic [ROW_W-1:0]  row,
                                            logic [COL_W-1:0]  col);
    console_cmd_t c;
    c = '{func, ch, attr, row, col};
    return c;
  endfunction

  function automatic console_cmd_t random_command();
    console_cmd_t c;
    int pick;
    c.func      = FUNC_PUT;
    c.char_code = CHAR_W'($urandom_range(255));
    c.attribute = ATTR_W'($urandom_range(255));
    c.read_row  = ROW_W'($urandom_range(31));
    c.read_col  = COL_W'($urandom_range(127));
    pick = $urandom_range(999);
    if (pick < 560) begin
      while (c.char_code == CH_NEWLINE || c.char_code == CH_BACKSPACE)
        c.char_code = CHAR_W'($urandom_range(255));
    end else if (pick < 720) c.char_code = CH_NEWLINE;
    else if (pick < 800) c.char_code = CH_BACKSPACE;
    else if (pick < 975) c.func = FUNC_READ;
    else if (pick < 993) c.func = FUNC_UNUSED;
    else c.func = FUNC_CLEAR;
    // most would-be scrolls on the bottom row become reads instead
    if (c.func == FUNC_PUT && board.row_now == SCREEN_ROWS-1 &&
        (c.char_code == CH_NEWLINE ||
         (c.char_code != CH_BACKSPACE && board.col_now == SCREEN_COLS-1)) &&
        (board.scrolls >= SCROLL_BUDGET || $urandom_range(3) != 0))
      c.func = FUNC_READ;
    if (c.func == FUNC_READ) begin
      case ($urandom_range(5))
        0, 1: begin
          c.read_row = ROW_W'(board.row_now);
          c.read_col = COL_W'($urandom_range(board.col_now));
        end
        2, 3: begin
          c.read_row = ROW_W'($urandom_range(SCREEN_ROWS-1));
          c.read_col = COL_W'($urandom_range(SCREEN_COLS-1));
        end
        4: begin
          c.read_row = ROW_W'($urandom_range(31, SCREEN_ROWS-1));
          c.read_col = COL_W'($urandom_range(127, SCREEN_COLS-1));
        end
        default: ;
      endcase
    end
    return c;
  endfunction

  // the beat is taken at the edge where ready is seen high; note it at once so
  // the mirror is current before the next command is generated
  task automatic push_cmd(console_cmd_t c);
    if ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.func      <= c.func;
    cmd_ch.char_code <= c.char_code;
    cmd_ch.attribute <= c.attribute;
    cmd_ch.read_row  <= c.read_row;
    cmd_ch.read_col  <= c.read_col;
    do @(posedge clk); while (!cmd_ch.ready);
    board.note_command(c);
  endtask

  task automatic drain_reports();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  initial begin
    rst              <= 1'b1;
    cmd_ch.valid     <= 1'b0;
    cmd_ch.func      <= FUNC_PUT;
    cmd_ch.char_code <= '0;
    cmd_ch.attribute <= '0;
    cmd_ch.read_row  <= '0;
    cmd_ch.read_col  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: corners of the screen, control characters, odd codes
    push_cmd(make_cmd(FUNC_READ,   8'h00,        8'h00, 5'd0,  7'd0));
    push_cmd(make_cmd(FUNC_READ,   8'h00,        8'h00, 5'd24, 7'd79));
    push_cmd(make_cmd(FUNC_PUT,    8'h41,        8'h1F, 5'd0,  7'd0));
    push_cmd(make_cmd(FUNC_PUT,    8'hFF,        8'hFF, 5'd31, 7'd127));
    push_cmd(make_cmd(FUNC_PUT,    8'h00,        8'h00, 5'd0,  7'd0));
    push_cmd(make_cmd(FUNC_READ,   8'h00,        8'h00, 5'd0,  7'd0));
    push_cmd(make_cmd(FUNC_READ,   8'h00,        8'h00, 5'd0,  7'd2));
    push_cmd(make_cmd(FUNC_PUT,    CH_BACKSPACE, 8'h5A, 5'd0,  7'd0));
    push_cmd(make_cmd(FUNC_READ,   8'h00,        8'h00, 5'd0,  7'd2));
    push_cmd(make_cmd(FUNC_PUT,    CH_BACKSPACE, 8'h11, 5'd0,  7'd0));
    push_cmd(make_cmd(FUNC_PUT,    CH_BACKSPACE, 8'h22, 5'd0,  7'd0));
    push_cmd(make_cmd(FUNC_PUT,    CH_BACKSPACE, 8'hC3, 5'd0,  7'd0));
    push_cmd(make_cmd(FUNC_PUT,    CH_NEWLINE,   8'h00, 5'd0,  7'd0));
    push_cmd(make_cmd(FUNC_PUT,    8'h7E,        8'h80, 5'd0,  7'd0));
    push_cmd(make_cmd(FUNC_READ,   8'h00,        8'h00, 5'd25, 7'd0));
    push_cmd(make_cmd(FUNC_READ,   8'h00,        8'h00, 5'd31, 7'd127));
    push_cmd(make_cmd(FUNC_READ,   8'h00,        8'h00, 5'd0,  7'd80));
    push_cmd(make_cmd(FUNC_READ,   8'h00,        8'h00, 5'd1,  7'd0));
    push_cmd(make_cmd(FUNC_UNUSED, 8'hFF,        8'hFF, 5'd31, 7'd127));
    push_cmd(make_cmd(FUNC_CLEAR,  8'h55,        8'hAA, 5'd3,  7'd9));
    push_cmd(make_cmd(FUNC_READ,   8'h00,        8'h00, 5'd1,  7'd0));
    push_cmd(make_cmd(FUNC_PUT,    CH_SPACE,     8'h07, 5'd0,  7'd0));
    push_cmd(make_cmd(FUNC_READ,   8'h00,        8'h00, 5'd0,  7'd0));
    drain_reports();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_plan[p];
      recv_stall_pct = recv_plan[p];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // receiver goes quiet mid-phase while command beats keep coming
        if (p == 2 && i == PHASE_ITEMS/2) hold_rx_req = 1'b1;
        push_cmd(random_command());
      end
      drain_reports();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d commands: %0d characters, %0d scrolls, %0d clears, %0d reads (%0d off screen)",
             board.commands, board.chars, board.scrolls, board.clears,
             board.reads, board.stray_reads);
    $display("idling: none, sender only, receiver only, both; one long receiver hold-off");
    if (board.mismatches == 0 && board.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
